// ===== design/mexp_pkg.sv =====
// Shared types, constants and control structs for the modular exponentiation unit.
// No dependencies.
package mexp_pkg;

  localparam int EXP_BITS = 32;
  localparam int CNT_W    = $clog2(EXP_BITS + 1);
  localparam int RES_W    = 30;
  localparam int POW_W    = 32;

  typedef logic [RES_W-1:0] residue_t;
  typedef logic [POW_W-1:0] power_t;
  typedef logic [EXP_BITS-1:0] exp_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // 1e9 + 7 and floor(2^60 / (1e9 + 7)) for Barrett reduction
  localparam residue_t PRIME_MOD = 30'd1000000007;
  localparam logic [30:0] BARRETT_M = 31'd1152921496;

  typedef struct packed {
    logic load;
    logic mul_start;
    logic mul_base;
    logic shift;
    logic out_load;
  } mexp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic exp_bit;
    logic last_bit;
  } mexp_sts_t;

endpackage

// ===== design/mexp_if.sv =====
// Valid/ready channel interfaces for operands and results.
// Depends on mexp_pkg.
interface mexp_in_if;
  import mexp_pkg::*;

  logic     valid;
  logic     ready;
  residue_t base_value;
  power_t   power;

  modport source (output valid, output base_value, output power, input ready);
  modport sink (input valid, input base_value, input power, output ready);
endinterface

interface mexp_out_if;
  import mexp_pkg::*;

  logic     valid;
  logic     ready;
  residue_t residue;

  modport source (output valid, output residue, input ready);
  modport sink (input valid, input residue, output ready);
endinterface

// ===== design/modular_exponentiation_unit.sv =====
// Top level: base^power mod 1e9+7 by MSB-first square-and-multiply.
// Depends on mexp_pkg, mexp_if, mexp_ctrl, mexp_datapath.
//
//   channel  dir  payload                               transaction when
//   in_i     in   base_value[29:0], power[31:0]         valid && ready
//   out_o    out  residue[29:0]                         valid && ready
//
// The result turns valid once every exponent bit has been squared and, where set,
// multiplied; the next input can be taken as soon as the result turns valid. The
// shared five-stage Barrett multiplier serves every square and multiply.
// Reset is asynchronous, active low, and clears the controller and multiplier valids.
// Result sits in an output register; the next input is taken while it waits,
// and only the hand-off of a new result stalls on a full output register.
module modular_exponentiation_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  mexp_in_if.sink           in_i,
  mexp_out_if.source        out_o
);
  import mexp_pkg::*;

  mexp_cmd_t cmd;
  mexp_sts_t sts;

  mexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mexp_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .base_value_i (in_i.base_value),
    .power_i      (in_i.power),
    .residue_o    (out_o.residue)
  );

endmodule

// ===== design/mexp_modmul.sv =====
// Pipelined modular multiplier mod 1e9+7, Barrett reduction.
// Depends on mexp_pkg.
module mexp_modmul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  mexp_pkg::residue_t a_i,
  input  mexp_pkg::residue_t b_i,
  output logic               done_o,
  output mexp_pkg::residue_t result_o
);
  import mexp_pkg::*;

  localparam int LAT = 5;
  localparam logic [31:0] P1 = {2'b00, PRIME_MOD};
  localparam logic [31:0] P2 = {1'b0, PRIME_MOD, 1'b0};

  logic [LAT-1:0] vld_q, vld_d;
  logic [59:0] prod_q, prod_d;
  logic [61:0] q2_q, q2_d;
  logic [31:0] xlo2_q, xlo3_q;
  logic [60:0] q3p_full;
  logic [31:0] q3p_q;
  logic [31:0] r_q, r_d;
  logic [31:0] fin_d;
  residue_t    res_q;

  assign vld_d    = {vld_q[LAT-2:0], start_i};
  assign prod_d   = a_i * b_i;
  assign q2_d     = prod_q[59:29] * BARRETT_M;
  assign q3p_full = q2_q[61:31] * PRIME_MOD;
  assign r_d      = xlo3_q - q3p_q;

  always_comb begin
    if (r_q >= P2) begin
      fin_d = r_q - P2;
    end else if (r_q >= P1) begin
      fin_d = r_q - P1;
    end else begin
      fin_d = r_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    q2_q   <= q2_d;
    xlo2_q <= prod_q[31:0];
    q3p_q  <= q3p_full[31:0];
    xlo3_q <= xlo2_q;
    r_q    <= r_d;
    res_q  <= fin_d[RES_W-1:0];
  end

  assign done_o   = vld_q[LAT-1];
  assign result_o = res_q;

endmodule

// ===== design/mexp_datapath.sv =====
// Datapath: base, accumulator, exponent shifter, bit counter, result register.
// Depends on mexp_pkg and mexp_modmul.
module mexp_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mexp_pkg::mexp_cmd_t cmd_i,
  output mexp_pkg::mexp_sts_t sts_o,
  input  mexp_pkg::residue_t  base_value_i,
  input  mexp_pkg::power_t    power_i,
  output mexp_pkg::residue_t  residue_o
);
  import mexp_pkg::*;

  residue_t base_q, base_d;
  residue_t acc_q, acc_d;
  exp_t     exp_q, exp_d;
  cnt_t     cnt_q, cnt_d;
  residue_t res_q, res_d;
  residue_t mm_b;
  residue_t mm_res;
  logic     mm_done;

  assign mm_b = cmd_i.mul_base ? base_q : acc_q;

  mexp_modmul u_modmul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.mul_start),
    .a_i      (acc_q),
    .b_i      (mm_b),
    .done_o   (mm_done),
    .result_o (mm_res)
  );

  always_comb begin
    base_d = base_q;
    acc_d  = acc_q;
    exp_d  = exp_q;
    cnt_d  = cnt_q;
    res_d  = res_q;
    if (cmd_i.load) begin
      base_d = (base_value_i >= PRIME_MOD) ? base_value_i - PRIME_MOD : base_value_i;
      acc_d  = RES_W'(1);
      exp_d  = EXP_BITS'(power_i);
      cnt_d  = CNT_W'(EXP_BITS);
    end
    if (mm_done) begin
      acc_d = mm_res;
    end
    if (cmd_i.shift) begin
      exp_d = exp_q << 1;
      cnt_d = cnt_q - CNT_W'(1);
    end
    if (cmd_i.out_load) begin
      res_d = acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    acc_q  <= acc_d;
    exp_q  <= exp_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
  end

  assign sts_o.mul_done = mm_done;
  assign sts_o.exp_bit  = exp_q[EXP_BITS-1];
  assign sts_o.last_bit = (cnt_q == CNT_W'(1));
  assign residue_o      = res_q;

endmodule

// ===== design/mexp_ctrl.sv =====
// Controller FSM sequencing square and multiply steps over the exponent bits.
// Depends on mexp_pkg.
module mexp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  mexp_pkg::mexp_sts_t sts_i,
  output mexp_pkg::mexp_cmd_t cmd_o
);
  import mexp_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_SQW  = 3'd2;
  localparam logic [2:0] ST_MU   = 3'd3;
  localparam logic [2:0] ST_MUW  = 3'd4;
  localparam logic [2:0] ST_NEXT = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       ovld_q, ovld_d;

  always_comb begin
    state_d = state_q;
    ovld_d  = ovld_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    if (ovld_q && out_ready_i) begin
      ovld_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd_o.mul_start = 1'b1;
        state_d         = ST_SQW;
      end
      ST_SQW: begin
        if (sts_i.mul_done) begin
          state_d = sts_i.exp_bit ? ST_MU : ST_NEXT;
        end
      end
      ST_MU: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_base  = 1'b1;
        state_d         = ST_MUW;
      end
      ST_MUW: begin
        if (sts_i.mul_done) begin
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (sts_i.last_bit) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.shift = 1'b1;
          state_d     = ST_SQ;
        end
      end
      ST_FIN: begin
        if (!ovld_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ovld_d         = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

  assign out_valid_o = ovld_q;

endmodule
